>>> rtl/core/wa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wa_pkg
// shared types and constants for the wirelength exponential-term core
// ----------------------------------------------------------------------------
package wa_pkg;

  // float unit operation codes
  typedef enum logic [1:0] {
    FP_ADD = 2'd0,
    FP_SUB = 2'd1,
    FP_MUL = 2'd2
  } fp_op_t;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_DNAN = 32'hFFC0_0000;  // default quiet nan
  localparam logic [31:0] FP_QBIT = 32'h0040_0000;

  // register index, taken from paddr[2]
  localparam logic REG_PINS  = 1'b0;
  localparam logic REG_GAMMA = 1'b1;

  localparam logic [6:0]  PINS_RESET  = 7'd2;
  localparam logic [31:0] GAMMA_RESET = 32'h3F80_0000;

  // unit request and response
  typedef struct packed {
    logic        start;
    fp_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fp_rsp_t;

endpackage

>>> rtl/core/wa_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wa_fpu
// three-stage ieee single add/sub/mul unit, round to nearest even
// ----------------------------------------------------------------------------
module wa_fpu import wa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  // stage a: unpack, specials, multiply or align and add
  logic        sa, sb, sbe;
  logic [7:0]  ea, eb, ea1, eb1;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        a_spec;
  logic [31:0] a_sres;
  logic [47:0] a_w;
  logic [11:0] a_x;
  logic        a_sign;
  logic        a_big;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  dcl;
  logic [23:0] m_big, m_sml;
  logic [53:0] al;
  logic [26:0] sml27;
  logic [27:0] sum;
  logic        s_big;

  always_comb begin
    sa = req.a[31]; ea = req.a[30:23]; fa = req.a[22:0];
    sb = req.b[31]; eb = req.b[30:23]; fb = req.b[22:0];
    sbe = (req.op == FP_SUB) ? ~sb : sb;
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    ea1 = (ea == 8'd0) ? 8'd1 : ea;
    eb1 = (eb == 8'd0) ? 8'd1 : eb;
    ma  = {ea != 8'd0, fa};
    mb  = {eb != 8'd0, fb};

    a_spec = 1'b1;
    a_sres = FP_DNAN;
    if (a_nan) begin
      a_sres = req.a | FP_QBIT;
    end else if (b_nan) begin
      a_sres = req.b | FP_QBIT;
    end else if (req.op == FP_MUL) begin
      if ((a_inf && b_zero) || (b_inf && a_zero)) begin
        a_sres = FP_DNAN;
      end else if (a_inf || b_inf) begin
        a_sres = {sa ^ sb, 8'hFF, 23'd0};
      end else begin
        a_spec = 1'b0;
      end
    end else begin
      if (a_inf && b_inf && (sa != sbe)) begin
        a_sres = FP_DNAN;
      end else if (a_inf) begin
        a_sres = req.a;
      end else if (b_inf) begin
        a_sres = {sbe, 8'hFF, 23'd0};
      end else begin
        a_spec = 1'b0;
      end
    end

    // alignment for add
    a_big = {ea1, ma} >= {eb1, mb};
    e_big = a_big ? ea1 : eb1;
    e_sml = a_big ? eb1 : ea1;
    m_big = a_big ? ma : mb;
    m_sml = a_big ? mb : ma;
    s_big = a_big ? sa : sbe;
    d     = e_big - e_sml;
    dcl   = (d > 8'd27) ? 5'd27 : d[4:0];
    al    = {m_sml, 3'b000, 27'd0} >> dcl;
    sml27 = al[53:27] | {26'd0, |al[26:0]};
    if (sa == sbe) begin
      sum = {1'b0, m_big, 3'b000} + {1'b0, sml27};
    end else begin
      sum = {1'b0, m_big, 3'b000} - {1'b0, sml27};
    end

    if (req.op == FP_MUL) begin
      a_w    = ma * mb;
      a_x    = {4'd0, ea1} + {4'd0, eb1} - 12'd300;
      a_sign = sa ^ sb;
    end else begin
      a_w    = {20'd0, sum};
      a_x    = {4'd0, e_big} - 12'd153;
      a_sign = (sum == 28'd0) ? (sa & sbe) : s_big;
    end
  end

  logic        va, vb, vc;
  logic [47:0] wa_q, wb_q;
  logic [11:0] xa_q, tb_q, sb_q;
  logic        sga_q, sgb_q, spa_q, spb_q, zb_q;
  logic [31:0] sra_q, srb_q, res_q;

  always_ff @(posedge clk) begin
    wa_q  <= a_w;
    xa_q  <= a_x;
    sga_q <= a_sign;
    spa_q <= a_spec;
    sra_q <= a_sres;
  end

  // stage b: leading one and shift amount
  logic [5:0]  lead;
  logic [11:0] xl, t_n;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (wa_q[i]) lead = 6'(i);
    end
    xl  = xa_q + {6'd0, lead} - 12'd23;
    t_n = ($signed(xl) < -12'sd149) ? 12'hF6B : xl;  // -149
  end

  always_ff @(posedge clk) begin
    wb_q  <= wa_q;
    tb_q  <= t_n;
    sb_q  <= t_n - xa_q;
    sgb_q <= sga_q;
    spb_q <= spa_q;
    srb_q <= sra_q;
    zb_q  <= (wa_q == 48'd0);
  end

  // stage c: shift, round, pack
  logic [5:0]  scl, lsh;
  logic [97:0] sh;
  logic [47:0] wl;
  logic [23:0] m;
  logic        g, st, inc;
  logic [24:0] mr;
  logic [11:0] fld;
  logic [22:0] frac;
  logic [31:0] res_n;

  always_comb begin
    lsh = 6'(-sb_q);
    scl = ($signed(sb_q) > 12'sd50) ? 6'd50 : sb_q[5:0];
    sh  = {wb_q, 50'd0} >> scl;
    wl  = wb_q << lsh;
    if ($signed(sb_q) <= 12'sd0) begin
      m = wl[23:0]; g = 1'b0; st = 1'b0;
    end else begin
      m = sh[73:50]; g = sh[49]; st = |sh[48:0];
    end
    inc = g & (st | m[0]);
    mr  = {1'b0, m} + {24'd0, inc};
    if (mr[24]) begin
      fld = tb_q + 12'd151; frac = 23'd0;
    end else if (mr[23]) begin
      fld = tb_q + 12'd150; frac = mr[22:0];
    end else begin
      fld = 12'd0; frac = mr[22:0];
    end
    // specials first: nan and inf operands can give a zero product or sum
    if (spb_q) begin
      res_n = srb_q;
    end else if (zb_q) begin
      res_n = {sgb_q, 31'd0};
    end else if ($signed(fld) >= 12'sd255) begin
      res_n = {sgb_q, 8'hFF, 23'd0};
    end else begin
      res_n = {sgb_q, fld[7:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else begin
      va <= req.start; vb <= va; vc <= vb;
    end
  end

  assign rsp.done = vc;
  assign rsp.res  = res_q;

endmodule

>>> rtl/core/wa_wirelength_exp_weights_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wa_wirelength_exp_weights_core
// weighted-average wirelength exponential terms, one shared float unit
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       s_tdata: coord_bits
//  m_*       out   m_tvalid / m_tready       m_tdata: a_plus, a_minus, pin_slot;
//                                            m_tlast: last_of_run
//  apb       in    psel/penable/pwrite       paddr 0: pins_per_net, 4: 1/gamma
//
//  the max pin is only stored as net_max; every other pin runs exponential
//  terms on the shared three-stage float unit, (SQUARINGS + 4) operations
//  per term, each issued after the result of the one before: the min pin
//  one term, other pins two terms; each result is then loaded into the
//  output register
//  s_tready is high only while the sequencer is idle; a stalled output holds
//  the result register and the sequencer waits before loading the next one
//  synchronous active-high reset clears position, net bounds and registers
module wa_wirelength_exp_weights_core import wa_pkg::*; #(
  parameter int MAX_PINS  = 64,
  parameter int SQUARINGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] coord_bits
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,    // [31:0] a_plus_bits, [63:32] a_minus_bits,
                                  // [69:64] pin_slot, [71:70] zero
  output logic        m_tlast,    // last_of_run
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(MAX_PINS);
  localparam int CW = (PW + 1 > 7) ? PW + 1 : 7;
  localparam int SW = $clog2(SQUARINGS + 4);
  localparam logic [SW-1:0] LAST_STEP = SW'(SQUARINGS + 3);
  localparam logic [31:0] SCALE = {1'b0, 8'(127 - SQUARINGS), 23'd0};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_PUT_A = 5'b01000,
    S_PUT_B = 5'b10000
  } state_t;

  state_t state;

  // config registers
  logic [6:0]  pins_per_net;
  logic [31:0] gamma_recip;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pins_per_net <= PINS_RESET;
      gamma_recip  <= GAMMA_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PINS:  pins_per_net <= pwdata[6:0];
        REG_GAMMA: gamma_recip  <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PINS:  prdata = {25'd0, pins_per_net};
      REG_GAMMA: prdata = gamma_recip;
      default:   prdata = 32'd0;
    endcase
  end

  // net state
  logic [PW-1:0] pin_position, cur_pos;
  logic [31:0]   net_max, net_min, cur_x;
  logic [CW-1:0] n_eff, ppn, pos_inc;
  logic          in_acc;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // clamp the pin count into [2, MAX_PINS]
  always_comb begin
    ppn = CW'(pins_per_net);
    if (ppn < CW'(2)) n_eff = CW'(2);
    else if (ppn > CW'(MAX_PINS)) n_eff = CW'(MAX_PINS);
    else n_eff = ppn;
    pos_inc = CW'(pin_position) + CW'(1);
  end

  // sequencer registers
  logic          term;       // 0: exp(x - max), 1: exp(min - x)
  logic [SW-1:0] step;
  logic [31:0]   acc, res_plus;
  fp_req_t       req;
  fp_rsp_t       rsp;
  logic          is_min_pin;

  assign is_min_pin = (cur_pos == PW'(1));

  wa_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // operand selection for the current step of the term
  always_comb begin
    req.start = (state == S_ISSUE);
    req.op    = FP_MUL;
    req.a     = acc;
    req.b     = acc;
    if (step == SW'(0)) begin
      req.op = FP_SUB;
      req.a  = term ? net_min : cur_x;
      req.b  = term ? cur_x : net_max;
    end else if (step == SW'(1)) begin
      req.a  = gamma_recip;
      req.b  = acc;
    end else if (step == SW'(2)) begin
      req.b  = SCALE;
    end else if (step == SW'(3)) begin
      req.op = FP_ADD;
      req.b  = FP_ONE;
    end
  end

  // output register
  logic        out_free, out_load;
  logic [31:0] ld_plus, ld_minus;
  logic [5:0]  ld_slot;
  logic        ld_last;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == S_PUT_A) || (state == S_PUT_B));

  always_comb begin
    if (state == S_PUT_B) begin
      ld_plus = acc; ld_minus = FP_ONE; ld_slot = 6'd1; ld_last = 1'b1;
    end else if (is_min_pin) begin
      // max pin result of the min item
      ld_plus = FP_ONE; ld_minus = acc; ld_slot = 6'd0; ld_last = 1'b0;
    end else begin
      ld_plus = res_plus; ld_minus = acc; ld_slot = 6'(cur_pos); ld_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, ld_slot, ld_minus, ld_plus};
      m_tlast <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pin_position <= '0;
      net_max      <= 32'd0;
      net_min      <= 32'd0;
      term         <= 1'b0;
      step         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pin_position <= (pos_inc >= n_eff) ? '0 : pos_inc[PW-1:0];
            cur_pos      <= pin_position;
            cur_x        <= s_tdata;
            term         <= 1'b0;
            step         <= '0;
            if (pin_position == '0) begin
              net_max <= s_tdata;
            end else begin
              if (pin_position == PW'(1)) net_min <= s_tdata;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            acc <= rsp.res;
            if (step == LAST_STEP) begin
              step <= '0;
              if (!term) res_plus <= rsp.res;
              // the min pin needs only exp(min - max)
              if (term || is_min_pin) begin
                state <= S_PUT_A;
              end else begin
                term  <= 1'b1;
                state <= S_ISSUE;
              end
            end else begin
              step  <= step + SW'(1);
              state <= S_ISSUE;
            end
          end
        end
        S_PUT_A: begin
          if (out_free) state <= is_min_pin ? S_PUT_B : S_IDLE;
        end
        S_PUT_B: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
